/* src/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue cells and top level.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH      = 16;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   localparam logic KIND_ENQ = 1'b0;
   localparam logic KIND_DEQ = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] item_data;
      logic signed [15:0] item_priority;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] head_data;
      logic               head_valid;
      logic [4:0]         entry_count;
      status_type         status;
   } rsp_word_type;

   typedef struct packed {
      logic signed [31:0] data;
      logic signed [15:0] prio;
   } entry_type;

   typedef struct packed {
      logic      ins;
      logic      deq;
      entry_type item;
   } cmd_type;

endpackage

/* src/stable_priority_queue_top.sv */
// A result word is registered and appears in the cycle after its request word is accepted.
// Throughput: one request word per cycle unless stalled; every cell compares
// against the new priority and shifts in the same cycle, setting the rate.
// Request stall rises only while a result word is held and stalled.
// Reset clears the entry count and the result valid; slot contents are not
// cleared and are read only below the entry count.
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Bounded priority queue as a chain of compare-and-shift cells, highest
// priority at cell 0, first in first out among equal priorities.
// ----------------------------------------------------------------------------
module stable_priority_queue_top
   import spq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam logic [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(DEPTH);

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;
   logic                  req_accept;
   logic                  full, empty;
   cmd_type               cmd;

   entry_type cell_ff [DEPTH];
   entry_type cell_in [DEPTH];
   logic      cell_stay [DEPTH];

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign full       = (count_ff == COUNT_FULL);
   assign empty      = (count_ff == '0);

   assign cmd.ins       = req_accept && (req_word.kind == KIND_ENQ) && !full;
   assign cmd.deq       = req_accept && (req_word.kind == KIND_DEQ) && !empty;
   assign cmd.item.data = req_word.item_data;
   assign cmd.item.prio = req_word.item_priority;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_entry, right_entry;
      logic      left_stay;

      if (i == 0) begin : g_first
         assign left_entry = cmd.item;
         assign left_stay  = 1'b1;
      end else begin : g_mid
         assign left_entry = cell_ff[i-1];
         assign left_stay  = cell_stay[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = cell_ff[i];
      end else begin : g_inner
         assign right_entry = cell_ff[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (count_ff > COUNT_BITS'(i)),
         .left_entry  (left_entry),
         .left_stay   (left_stay),
         .right_entry (right_entry),
         .entry_ff    (cell_ff[i]),
         .entry_in    (cell_in[i]),
         .stay        (cell_stay[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      priority if (cmd.ins) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (cmd.deq) begin
         count_in = count_ff - COUNT_BITS'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      rsp_word_in.head_valid  = (count_in != '0);
      rsp_word_in.head_data   = (count_in != '0) ? cell_in[0].data : '0;
      rsp_word_in.entry_count = 5'(count_in);
      priority if (req_word.kind == KIND_ENQ && full) begin
         rsp_word_in.status = STATUS_FULL;
      end else if (req_word.kind == KIND_DEQ && empty) begin
         rsp_word_in.status = STATUS_EMPTY;
      end else begin
         rsp_word_in.status = STATUS_OK;
      end
   end

   assign rsp_valid_in = req_accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL)
      else $error("entry count above depth");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_word.kind == KIND_ENQ && full |=> count_ff == COUNT_FULL)
      else $error("enqueue on full queue changed the count");

   a_deq_count: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_word.kind == KIND_DEQ && !empty
      |=> count_ff == $past(count_ff) - COUNT_BITS'(1))
      else $error("dequeue did not drop one entry");

   a_rsp_valid_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_word_ff.head_valid == (rsp_word_ff.entry_count != 5'd0))
      else $error("head valid disagrees with entry count");

   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff && rsp_word_ff.entry_count == 5'(count_ff))
      else $error("result word missing or count mismatch");

endmodule

/* src/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: keep, take the new entry, or shift from a
// neighbor, based on the command, its own compare and the left neighbor's compare.
// ----------------------------------------------------------------------------
module spq_cell
   import spq_pkg::*;
(
   input  logic      clock,
   input  cmd_type   cmd,
   input  logic      occupied,
   input  entry_type left_entry,
   input  logic      left_stay,
   input  entry_type right_entry,
   output entry_type entry_ff,
   output entry_type entry_in,
   output logic      stay
);

   assign stay = occupied && (entry_ff.prio >= cmd.item.prio);

   always_comb begin
      entry_in = entry_ff;
      priority if (cmd.ins) begin
         if (!stay) begin
            entry_in = left_stay ? cmd.item : left_entry;
         end
      end else if (cmd.deq) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
